### src/mmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_pkg
// Types, token codes and character-class helpers for the maximal munch
// tokenizer.
// ----------------------------------------------------------------------------
package mmt_pkg;

  localparam int POS_BITS  = 16;          // position / length counter width
  localparam int OUT_BITS  = 16;          // reported position / length width
  localparam int CHAR_BITS = 8;
  localparam int KW_BYTES  = 5;           // longest keyword
  localparam int KW_BITS   = KW_BYTES * CHAR_BITS;
  localparam int BATCH_MAX = 3;           // results one byte can cause
  localparam int CNT_BITS  = $clog2(BATCH_MAX + 1);
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_LW      = $clog2(Q_DEPTH + 1);

  localparam logic [KW_BITS-1:0] KW_PRINT_TXT = "print";
  localparam logic [KW_BITS-1:0] KW_IF_TXT    = "if";
  localparam logic [KW_BITS-1:0] KW_ELSE_TXT  = "else";
  localparam logic [KW_BITS-1:0] KW_FOR_TXT   = "for";
  localparam logic [KW_BITS-1:0] KW_TRUE_TXT  = "true";
  localparam logic [KW_BITS-1:0] KW_FALSE_TXT = "false";

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [4:0] {
    TK_INT        = 5'd0,
    TK_FLOAT      = 5'd1,
    TK_IDENT      = 5'd2,
    TK_STRING     = 5'd3,
    TK_ASSIGN     = 5'd4,
    TK_ADD_ASSIGN = 5'd5,
    TK_SUB_ASSIGN = 5'd6,
    TK_MINUS      = 5'd7,
    TK_PLUS       = 5'd8,
    TK_STAR       = 5'd9,
    TK_SLASH      = 5'd10,
    TK_PERCENT    = 5'd11,
    TK_SEMI       = 5'd12,
    TK_LPAREN     = 5'd13,
    TK_RPAREN     = 5'd14,
    TK_LBRACE     = 5'd15,
    TK_RBRACE     = 5'd16,
    TK_LT         = 5'd17,
    TK_LE         = 5'd18,
    TK_GT         = 5'd19,
    TK_GE         = 5'd20,
    TK_EQ         = 5'd21,
    TK_OR         = 5'd22,
    TK_AND        = 5'd23,
    TK_KW_PRINT   = 5'd24,
    TK_KW_IF      = 5'd25,
    TK_KW_ELSE    = 5'd26,
    TK_KW_FOR     = 5'd27,
    TK_KW_TRUE    = 5'd28,
    TK_KW_FALSE   = 5'd29,
    TK_EOI        = 5'd30
  } kind_t;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_IDENT = 5'b00010,
    MODE_NUM   = 5'b00100,
    MODE_STR   = 5'b01000,
    MODE_OP    = 5'b10000
  } mode_t;

  typedef struct packed {
    kind_t               kind;
    logic [OUT_BITS-1:0] start_position;
    logic [OUT_BITS-1:0] token_length;
    logic                lex_error;
    logic                run_last;
  } result_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]          cnt;
    result_t [BATCH_MAX-1:0]      item;
  } batch_t;

  typedef struct packed {
    logic [Q_LW-1:0] level;
    logic            room;
  } qstat_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } op_hit_t;

  typedef struct packed {
    logic  ok;
    logic  emit;
    kind_t kind;
    pos_t  len;
  } close_t;

  function automatic logic [OUT_BITS-1:0] to_out(input pos_t p);
    logic [POS_BITS+OUT_BITS-1:0] w;
    w = {{OUT_BITS{1'b0}}, p};
    return w[OUT_BITS-1:0];
  endfunction

  function automatic result_t make_res(input kind_t k, input pos_t start, input pos_t len,
                                       input logic err);
    result_t r;
    r.kind           = k;
    r.start_position = to_out(start);
    r.token_length   = to_out(len);
    r.lex_error      = err;
    r.run_last       = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  // space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic opens_pair(input logic [CHAR_BITS-1:0] c);
    return (c == "=") || (c == "+") || (c == "-") || (c == "<") || (c == ">") ||
           (c == "|") || (c == "&");
  endfunction

  function automatic op_hit_t single_kind(input logic [CHAR_BITS-1:0] c);
    op_hit_t r;
    r.hit  = 1'b1;
    r.kind = TK_INT;
    case (c)
      "*":     r.kind = TK_STAR;
      "/":     r.kind = TK_SLASH;
      "%":     r.kind = TK_PERCENT;
      ";":     r.kind = TK_SEMI;
      "(":     r.kind = TK_LPAREN;
      ")":     r.kind = TK_RPAREN;
      "{":     r.kind = TK_LBRACE;
      "}":     r.kind = TK_RBRACE;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic op_hit_t lone_kind(input logic [CHAR_BITS-1:0] c);
    op_hit_t r;
    r.hit  = 1'b1;
    r.kind = TK_INT;
    case (c)
      "=":     r.kind = TK_ASSIGN;
      "+":     r.kind = TK_PLUS;
      "-":     r.kind = TK_MINUS;
      "<":     r.kind = TK_LT;
      ">":     r.kind = TK_GT;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic op_hit_t pair_kind(input logic [CHAR_BITS-1:0] first,
                                        input logic [CHAR_BITS-1:0] second);
    op_hit_t r;
    r.hit  = 1'b0;
    r.kind = TK_INT;
    if (second == "=") begin
      r.hit = 1'b1;
      case (first)
        "+":     r.kind = TK_ADD_ASSIGN;
        "-":     r.kind = TK_SUB_ASSIGN;
        "<":     r.kind = TK_LE;
        ">":     r.kind = TK_GE;
        "=":     r.kind = TK_EQ;
        default: r.hit  = 1'b0;
      endcase
    end else if ((first == "|") && (second == "|")) begin
      r.hit  = 1'b1;
      r.kind = TK_OR;
    end else if ((first == "&") && (second == "&")) begin
      r.hit  = 1'b1;
      r.kind = TK_AND;
    end
    return r;
  endfunction

  // prefix holds at most the first five bytes, right-justified
  function automatic kind_t ident_kind(input pos_t len, input logic [KW_BITS-1:0] pf);
    kind_t k;
    k = TK_IDENT;
    if ((len == POS_BITS'(5)) && (pf == KW_PRINT_TXT)) k = TK_KW_PRINT;
    if ((len == POS_BITS'(2)) && (pf == KW_IF_TXT))    k = TK_KW_IF;
    if ((len == POS_BITS'(4)) && (pf == KW_ELSE_TXT))  k = TK_KW_ELSE;
    if ((len == POS_BITS'(3)) && (pf == KW_FOR_TXT))   k = TK_KW_FOR;
    if ((len == POS_BITS'(4)) && (pf == KW_TRUE_TXT))  k = TK_KW_TRUE;
    if ((len == POS_BITS'(5)) && (pf == KW_FALSE_TXT)) k = TK_KW_FALSE;
    return k;
  endfunction

  // Token ended by whatever follows it; ok is low when the text so far is not a token.
  function automatic close_t close_tok(input mode_t m, input pos_t len,
                                       input logic [KW_BITS-1:0] pf,
                                       input logic ps, input logic ds);
    close_t  r;
    op_hit_t lk;
    r.ok   = 1'b1;
    r.emit = 1'b0;
    r.kind = TK_INT;
    r.len  = len;
    lk     = lone_kind(pf[CHAR_BITS-1:0]);
    unique case (m)
      MODE_IDENT: begin
        r.emit = 1'b1;
        r.kind = ident_kind(len, pf);
      end
      MODE_NUM: begin
        if (ds) begin
          r.emit = 1'b1;
          r.kind = ps ? TK_FLOAT : TK_INT;
        end else begin
          r.ok = 1'b0;
        end
      end
      MODE_STR: r.ok = 1'b0;
      MODE_OP: begin
        if (lk.hit) begin
          r.emit = 1'b1;
          r.kind = lk.kind;
          r.len  = POS_BITS'(1);
        end else begin
          r.ok = 1'b0;
        end
      end
      default: r.ok = 1'b1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/mmt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmt channel interfaces
// Valid/ready channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface mmt_in_if;
  logic                           valid;
  logic                           ready;
  logic [mmt_pkg::CHAR_BITS-1:0]  char_code;
  logic                           end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface mmt_out_if;
  logic                           valid;
  logic                           ready;
  logic [4:0]                     token_kind;
  logic [mmt_pkg::OUT_BITS-1:0]   start_position;
  logic [mmt_pkg::OUT_BITS-1:0]   token_length;
  logic                           lex_error;
  logic                           run_last;

  modport source (output valid, token_kind, start_position, token_length, lex_error,
                  run_last, input ready);
  modport sink   (input valid, token_kind, start_position, token_length, lex_error,
                  run_last, output ready);
endinterface
`default_nettype wire

### src/mmt_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_scan
// Scanner state and the per-byte step: updates the open token and produces
// the batch of up to three results caused by one accepted byte.
// ----------------------------------------------------------------------------
module mmt_scan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_fire,
  input  logic [mmt_pkg::CHAR_BITS-1:0]  char_code,
  input  logic                           end_of_text,
  output mmt_pkg::batch_t                batch
);

  mmt_pkg::mode_t                  mode_r,   mode_nxt;
  mmt_pkg::pos_t                   start_r,  start_nxt;
  mmt_pkg::pos_t                   len_r,    len_nxt;
  logic [mmt_pkg::KW_BITS-1:0]     prefix_r, prefix_nxt;
  logic                            period_r, period_nxt;
  logic                            digit_r,  digit_nxt;
  mmt_pkg::pos_t                   pos_r,    pos_nxt;
  logic                            err_r,    err_nxt;

  mmt_pkg::result_t [mmt_pkg::BATCH_MAX-1:0] res;
  logic [mmt_pkg::CNT_BITS-1:0]    n;
  logic                            fail;
  logic                            fresh;
  mmt_pkg::pos_t                   fail_at;
  mmt_pkg::close_t                 cl;
  mmt_pkg::op_hit_t                sk;
  mmt_pkg::op_hit_t                pk;
  logic [mmt_pkg::CHAR_BITS-1:0]   c;

  assign c = char_code;

  always_comb begin
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    prefix_nxt = prefix_r;
    period_nxt = period_r;
    digit_nxt  = digit_r;
    pos_nxt    = pos_r;
    err_nxt    = err_r;
    res        = '0;
    n          = '0;
    fail       = 1'b0;
    fresh      = 1'b1;
    fail_at    = pos_r;
    cl         = '0;
    sk         = mmt_pkg::single_kind(c);
    pk         = mmt_pkg::pair_kind(prefix_r[mmt_pkg::CHAR_BITS-1:0], c);

    if (!err_r) begin
      if (&pos_r) begin
        // position range used up: drop the open token
        fail  = 1'b1;
        fresh = 1'b0;
      end else begin
        unique case (mode_r)
          mmt_pkg::MODE_IDLE: fresh = 1'b1;
          mmt_pkg::MODE_IDENT: begin
            if (mmt_pkg::is_letter(c) || mmt_pkg::is_digit(c)) begin
              if (len_r < mmt_pkg::POS_BITS'(mmt_pkg::KW_BYTES)) begin
                prefix_nxt = {prefix_r[mmt_pkg::KW_BITS-mmt_pkg::CHAR_BITS-1:0], c};
              end
              len_nxt = len_r + 1'b1;
              fresh   = 1'b0;
            end else begin
              cl       = mmt_pkg::close_tok(mode_r, len_r, prefix_r, period_r, digit_r);
              mode_nxt = mmt_pkg::MODE_IDLE;
              res[n]   = mmt_pkg::make_res(cl.kind, start_r, cl.len, 1'b0);
              n        = n + 1'b1;
            end
          end
          mmt_pkg::MODE_NUM: begin
            if (mmt_pkg::is_digit(c)) begin
              digit_nxt = 1'b1;
              len_nxt   = len_r + 1'b1;
              fresh     = 1'b0;
            end else if ((c == ".") && !period_r) begin
              period_nxt = 1'b1;
              len_nxt    = len_r + 1'b1;
              fresh      = 1'b0;
            end else begin
              cl       = mmt_pkg::close_tok(mode_r, len_r, prefix_r, period_r, digit_r);
              mode_nxt = mmt_pkg::MODE_IDLE;
              if (!cl.ok) begin
                fail    = 1'b1;
                fail_at = start_r;
                fresh   = 1'b0;
              end else begin
                res[n] = mmt_pkg::make_res(cl.kind, start_r, cl.len, 1'b0);
                n      = n + 1'b1;
              end
            end
          end
          mmt_pkg::MODE_STR: begin
            len_nxt = len_r + 1'b1;
            fresh   = 1'b0;
            if (c == "\"") begin
              res[n]   = mmt_pkg::make_res(mmt_pkg::TK_STRING, start_r, len_nxt, 1'b0);
              n        = n + 1'b1;
              mode_nxt = mmt_pkg::MODE_IDLE;
            end
          end
          mmt_pkg::MODE_OP: begin
            mode_nxt = mmt_pkg::MODE_IDLE;
            if (pk.hit) begin
              res[n] = mmt_pkg::make_res(pk.kind, start_r, mmt_pkg::POS_BITS'(2), 1'b0);
              n      = n + 1'b1;
              fresh  = 1'b0;
            end else begin
              cl = mmt_pkg::close_tok(mode_r, len_r, prefix_r, period_r, digit_r);
              if (!cl.ok) begin
                fail    = 1'b1;
                fail_at = start_r;
                fresh   = 1'b0;
              end else begin
                res[n] = mmt_pkg::make_res(cl.kind, start_r, cl.len, 1'b0);
                n      = n + 1'b1;
              end
            end
          end
          default: fresh = 1'b1;
        endcase
      end

      if (fresh) begin
        if (mmt_pkg::is_space(c)) begin
          mode_nxt = mmt_pkg::MODE_IDLE;
        end else if (mmt_pkg::is_letter(c)) begin
          mode_nxt   = mmt_pkg::MODE_IDENT;
          start_nxt  = pos_r;
          len_nxt    = mmt_pkg::POS_BITS'(1);
          prefix_nxt = mmt_pkg::KW_BITS'(c);
          period_nxt = 1'b0;
          digit_nxt  = 1'b0;
        end else if (mmt_pkg::is_digit(c) || (c == ".")) begin
          mode_nxt   = mmt_pkg::MODE_NUM;
          start_nxt  = pos_r;
          len_nxt    = mmt_pkg::POS_BITS'(1);
          prefix_nxt = '0;
          period_nxt = (c == ".");
          digit_nxt  = mmt_pkg::is_digit(c);
        end else if (c == "\"") begin
          mode_nxt   = mmt_pkg::MODE_STR;
          start_nxt  = pos_r;
          len_nxt    = mmt_pkg::POS_BITS'(1);
          prefix_nxt = '0;
          period_nxt = 1'b0;
          digit_nxt  = 1'b0;
        end else if (sk.hit) begin
          res[n]   = mmt_pkg::make_res(sk.kind, pos_r, mmt_pkg::POS_BITS'(1), 1'b0);
          n        = n + 1'b1;
          mode_nxt = mmt_pkg::MODE_IDLE;
        end else if (mmt_pkg::opens_pair(c)) begin
          mode_nxt   = mmt_pkg::MODE_OP;
          start_nxt  = pos_r;
          len_nxt    = mmt_pkg::POS_BITS'(1);
          prefix_nxt = mmt_pkg::KW_BITS'(c);
          period_nxt = 1'b0;
          digit_nxt  = 1'b0;
        end else begin
          fail    = 1'b1;
          fail_at = pos_r;
        end
      end

      if (!fail) begin
        pos_nxt = pos_r + 1'b1;
        if (end_of_text) begin
          // close whatever is still open after this byte
          cl       = mmt_pkg::close_tok(mode_nxt, len_nxt, prefix_nxt, period_nxt, digit_nxt);
          mode_nxt = mmt_pkg::MODE_IDLE;
          if (!cl.ok) begin
            fail    = 1'b1;
            fail_at = start_nxt;
          end else begin
            if (cl.emit) begin
              res[n] = mmt_pkg::make_res(cl.kind, start_nxt, cl.len, 1'b0);
              n      = n + 1'b1;
            end
            res[n] = mmt_pkg::make_res(mmt_pkg::TK_EOI, pos_nxt, '0, 1'b0);
            n      = n + 1'b1;
          end
        end
      end

      if (fail) begin
        res[n]   = mmt_pkg::make_res(mmt_pkg::TK_INT, fail_at, '0, 1'b1);
        n        = n + 1'b1;
        mode_nxt = mmt_pkg::MODE_IDLE;
        err_nxt  = 1'b1;
      end
    end

    if (end_of_text) begin
      mode_nxt   = mmt_pkg::MODE_IDLE;
      start_nxt  = '0;
      len_nxt    = '0;
      prefix_nxt = '0;
      period_nxt = 1'b0;
      digit_nxt  = 1'b0;
      pos_nxt    = '0;
      err_nxt    = 1'b0;
    end

    if (n != '0) begin
      res[n - 1'b1].run_last = 1'b1;
    end
  end

  assign batch.cnt  = in_fire ? n : '0;
  assign batch.item = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mmt_pkg::MODE_IDLE;
      start_r  <= '0;
      len_r    <= '0;
      prefix_r <= '0;
      period_r <= 1'b0;
      digit_r  <= 1'b0;
      pos_r    <= '0;
      err_r    <= 1'b0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      prefix_r <= prefix_nxt;
      period_r <= period_nxt;
      digit_r  <= digit_nxt;
      pos_r    <= pos_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule
`default_nettype wire

### src/mmt_result_q.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_result_q
// Small result queue: takes a batch of up to three results per cycle and
// hands them to the output channel one beat at a time.
// ----------------------------------------------------------------------------
module mmt_result_q (
  input  logic              clk,
  input  logic              rst_n,
  input  mmt_pkg::batch_t   batch,
  mmt_out_if.source         out_chan,
  output mmt_pkg::qstat_t   stat
);

  mmt_pkg::result_t          mem_r [mmt_pkg::Q_DEPTH];
  logic [mmt_pkg::Q_AW-1:0]  wr_ptr_r;
  logic [mmt_pkg::Q_AW-1:0]  rd_ptr_r;
  logic [mmt_pkg::Q_LW-1:0]  level_r;
  logic                      pop;
  mmt_pkg::result_t          head;

  assign pop  = (level_r != '0) && out_chan.ready;
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + mmt_pkg::Q_AW'(batch.cnt);
      rd_ptr_r <= rd_ptr_r + mmt_pkg::Q_AW'(pop);
      level_r  <= level_r + mmt_pkg::Q_LW'(batch.cnt) - mmt_pkg::Q_LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < mmt_pkg::BATCH_MAX; i++) begin
      if (mmt_pkg::Q_LW'(i) < mmt_pkg::Q_LW'(batch.cnt)) begin
        mem_r[wr_ptr_r + mmt_pkg::Q_AW'(i)] <= batch.item[i];
      end
    end
  end

  // room for a full batch
  assign stat.level = level_r;
  assign stat.room  = (level_r <= mmt_pkg::Q_LW'(mmt_pkg::Q_DEPTH - mmt_pkg::BATCH_MAX));

  assign out_chan.valid          = (level_r != '0);
  assign out_chan.token_kind     = head.kind;
  assign out_chan.start_position = head.start_position;
  assign out_chan.token_length   = head.token_length;
  assign out_chan.lex_error      = head.lex_error;
  assign out_chan.run_last       = head.run_last;

endmodule
`default_nettype wire

### src/maximal_munch_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maximal_munch_tokenizer
// Longest-match tokenizer: text bytes in, tokens with kind, start and
// length out. Errors end the text; bytes are skipped until end of text.
// ----------------------------------------------------------------------------
//   channel   dir  beat                                              
//   in_chan   in   char_code, end_of_text                            
//   out_chan  out  token_kind, start_position, token_length,         
//                  lex_error, run_last                               
//
// One byte is taken per cycle if in_chan.ready is high; its results (0 to 3) are
// written into a 4-entry queue at the accepting edge and leave one beat per cycle
// if out_chan.ready is high. in_chan.ready is high while the queue holds at most
// one result, so single-result bytes stream at one per cycle if out_chan.ready is
// high; 2 or 3 results drop in_chan.ready. Synchronous active-low reset clears
// the scanner and queue; no pass over storage is needed.
// ----------------------------------------------------------------------------
module maximal_munch_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  mmt_in_if.sink     in_chan,
  mmt_out_if.source  out_chan
);

  mmt_pkg::batch_t  batch;
  mmt_pkg::qstat_t  stat;
  logic             in_fire;

  assign in_chan.ready = stat.room;
  assign in_fire       = in_chan.valid && stat.room;

  mmt_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .char_code   (in_chan.char_code),
    .end_of_text (in_chan.end_of_text),
    .batch       (batch)
  );

  mmt_result_q u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .batch    (batch),
    .out_chan (out_chan),
    .stat     (stat)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.level <= mmt_pkg::Q_LW'(mmt_pkg::Q_DEPTH))
    else $error("result queue overflow");

  a_valid_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(batch.cnt != '0))
    else $error("output valid without a pushed result");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.lex_error) |->
      (out_chan.token_length == '0) && out_chan.run_last &&
      (out_chan.token_kind == mmt_pkg::TK_INT))
    else $error("malformed error result");

  a_batch_fits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (stat.level + mmt_pkg::Q_LW'(mmt_pkg::BATCH_MAX)
                 <= mmt_pkg::Q_LW'(mmt_pkg::Q_DEPTH)))
    else $error("byte accepted without room for a full batch");
`endif

endmodule
`default_nettype wire
